// ----- sv/multi_channel_pipe_table_unit_assert.svh -----
// Assertion macros used by the pipe table controller.
`ifndef MULTI_CHANNEL_PIPE_TABLE_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PIPE_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MCPT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pipe table assertion failed");
// Next-cycle implication, checked out of reset.
`define MCPT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pipe table assertion failed");
`else
`define MCPT_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define MCPT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- sv/mcpt_pkg.sv -----
// Package: sizes, codes and controller/datapath interface types for the pipe table.
package mcpt_pkg;

  localparam int PIPES      = 8;
  localparam int RING_DEPTH = 256;

  localparam int IDX_W  = (PIPES > 1) ? $clog2(PIPES) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W = IDX_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int OP_W     = 3;
  localparam int ID_W     = 8;
  localparam int PID_W    = 15;
  localparam int BYTE_W   = 8;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;

  localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_ID  = 3'd1,
    ST_REFUSED = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_EOD     = 3'd5,
    ST_NO_FREE = 3'd6
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // execute the presented item this cycle
    logic rd_fill;  // capture ring read data into the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_ok;    // presented item is a read that returns a byte
  } dp_status_t;

endpackage

// ----- sv/mcpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mcpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/mcpt_ctrl.sv -----
// Controller: handshake control and read-wait sequencing for the pipe table.
`include "multi_channel_pipe_table_unit_assert.svh"
module mcpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mcpt_pkg::dp_status_t dp_status,
  output mcpt_pkg::dp_cmd_t   dp_cmd
);

  mcpt_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Result register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    dp_cmd.accept  = 1'b0;
    dp_cmd.rd_fill = 1'b0;
    in_stall       = 1'b1;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      mcpt_pkg::CS_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          dp_cmd.accept = 1'b1;
          if (dp_status.rd_ok) begin
            // wait in CS_READ for the registered ring read data
            state_nxt = mcpt_pkg::CS_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      mcpt_pkg::CS_READ: begin
        dp_cmd.rd_fill = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = mcpt_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = mcpt_pkg::CS_IDLE;
      end
    endcase
  end

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcpt_pkg::CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MCPT_ASSERT_NEXT(a_read_waits, clk, rst_n,
                    dp_cmd.accept && dp_status.rd_ok,
                    state_r == mcpt_pkg::CS_READ && !out_valid_r)
  `MCPT_ASSERT_NEXT(a_read_delivers, clk, rst_n,
                    state_r == mcpt_pkg::CS_READ, out_valid_r)
  `MCPT_ASSERT_NEXT(a_direct_result, clk, rst_n,
                    dp_cmd.accept && !dp_status.rd_ok, out_valid_r)
  `MCPT_ASSERT_NOW(a_no_overwrite, clk, rst_n,
                   dp_cmd.accept, !out_valid_r || !out_stall)

endmodule

// ----- sv/mcpt_dp.sv -----
// Datapath: pipe table state, operation decode, ring memory and result register.
module mcpt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mcpt_pkg::OP_W-1:0]           in_op,
  input  logic [mcpt_pkg::ID_W-1:0]           in_pipe_id,
  input  logic                                in_role,
  input  logic [mcpt_pkg::PID_W-1:0]          in_pid,
  input  logic [mcpt_pkg::BYTE_W-1:0]         in_data_in,
  input  logic                                in_end_of_transfer,
  output logic [mcpt_pkg::STATUS_W-1:0]       out_status,
  output logic [mcpt_pkg::BYTE_W-1:0]         out_data_out,
  output logic signed [mcpt_pkg::OWNER_W-1:0] out_owner_out,
  output logic [mcpt_pkg::ID_W-1:0]           out_pipe_out,
  output logic                                out_end_of_transfer_out,
  input  mcpt_pkg::dp_cmd_t                   dp_cmd,
  output mcpt_pkg::dp_status_t                dp_status
);

  localparam int P = mcpt_pkg::PIPES;

  logic [mcpt_pkg::OWNER_W-1:0] ro_r   [P];
  logic [mcpt_pkg::OWNER_W-1:0] ro_nxt [P];
  logic [mcpt_pkg::OWNER_W-1:0] wo_r   [P];
  logic [mcpt_pkg::OWNER_W-1:0] wo_nxt [P];
  logic [mcpt_pkg::PTR_W-1:0]   rp_r   [P];
  logic [mcpt_pkg::PTR_W-1:0]   rp_nxt [P];
  logic [mcpt_pkg::PTR_W-1:0]   wp_r   [P];
  logic [mcpt_pkg::PTR_W-1:0]   wp_nxt [P];
  logic [mcpt_pkg::CNT_W-1:0]   fill_r   [P];
  logic [mcpt_pkg::CNT_W-1:0]   fill_nxt [P];
  logic [P-1:0]                 free_r, free_nxt;

  logic [mcpt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [mcpt_pkg::OWNER_W-1:0]  owner_r, owner_nxt;
  logic [mcpt_pkg::ID_W-1:0]     pipe_r, pipe_nxt;
  logic                          eot_r;
  logic [mcpt_pkg::BYTE_W-1:0]   data_r;

  logic [mcpt_pkg::IDX_W-1:0]    idx;
  logic                          id_ok;
  logic [mcpt_pkg::OWNER_W-1:0]  pid_ext;
  logic [mcpt_pkg::OWNER_W-1:0]  ro_sel, wo_sel;
  logic [mcpt_pkg::PTR_W-1:0]    rp_sel, wp_sel;
  logic [mcpt_pkg::CNT_W-1:0]    fill_sel;
  logic [mcpt_pkg::IDX_W-1:0]    alloc_idx;
  logic                          alloc_found;
  logic                          r_rel, w_rel;
  logic [mcpt_pkg::OWNER_W-1:0]  ro_after, wo_after;
  logic                          ram_we, ram_re;
  logic [mcpt_pkg::BYTE_W-1:0]   ram_rd_data;

  // Select the addressed pipe
  assign idx     = in_pipe_id[mcpt_pkg::IDX_W-1:0];
  assign id_ok   = in_pipe_id < mcpt_pkg::ID_W'(P);
  assign pid_ext = {1'b0, in_pid};
  assign ro_sel   = ro_r[idx];
  assign wo_sel   = wo_r[idx];
  assign rp_sel   = rp_r[idx];
  assign wp_sel   = wp_r[idx];
  assign fill_sel = fill_r[idx];

  // First-fit search for an unused pipe
  always_comb begin
    alloc_idx   = '0;
    alloc_found = 1'b0;
    for (int i = 0; i < P; i++) begin
      if (!alloc_found && free_r[i] && ro_r[i] == mcpt_pkg::OWNER_NONE &&
          wo_r[i] == mcpt_pkg::OWNER_NONE) begin
        alloc_idx   = mcpt_pkg::IDX_W'(i);
        alloc_found = 1'b1;
      end
    end
  end

  // Close releases each role owned by the caller
  assign r_rel    = ro_sel == pid_ext;
  assign w_rel    = wo_sel == pid_ext;
  assign ro_after = r_rel ? mcpt_pkg::OWNER_NONE : ro_sel;
  assign wo_after = w_rel ? mcpt_pkg::OWNER_NONE : wo_sel;

  // Decode the operation into a result and next table state
  always_comb begin
    ro_nxt     = ro_r;
    wo_nxt     = wo_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    free_nxt   = free_r;
    status_nxt = mcpt_pkg::ST_OK;
    owner_nxt  = mcpt_pkg::OWNER_NONE;
    pipe_nxt   = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    dp_status.rd_ok = 1'b0;
    if (mcpt_pkg::op_t'(in_op) == mcpt_pkg::OP_ALLOC) begin
      if (alloc_found) begin
        free_nxt[alloc_idx] = 1'b0;
        pipe_nxt = mcpt_pkg::ID_W'(alloc_idx);
      end else begin
        status_nxt = mcpt_pkg::ST_NO_FREE;
      end
    end else if (!id_ok) begin
      status_nxt = mcpt_pkg::ST_BAD_ID;
    end else begin
      case (mcpt_pkg::op_t'(in_op))
        mcpt_pkg::OP_OPEN: begin
          if (in_role) begin
            if (wo_sel != mcpt_pkg::OWNER_NONE) begin
              status_nxt = mcpt_pkg::ST_REFUSED;
            end else begin
              wo_nxt[idx] = pid_ext;
            end
          end else begin
            if (ro_sel != mcpt_pkg::OWNER_NONE) begin
              status_nxt = mcpt_pkg::ST_REFUSED;
            end else begin
              ro_nxt[idx] = pid_ext;
            end
          end
        end
        mcpt_pkg::OP_CLOSE: begin
          ro_nxt[idx] = ro_after;
          wo_nxt[idx] = wo_after;
          if (ro_after == mcpt_pkg::OWNER_NONE && wo_after == mcpt_pkg::OWNER_NONE) begin
            rp_nxt[idx]   = '0;
            wp_nxt[idx]   = '0;
            fill_nxt[idx] = '0;
            free_nxt[idx] = 1'b1;
          end
          if (!(r_rel || w_rel)) begin
            status_nxt = mcpt_pkg::ST_REFUSED;
          end
        end
        mcpt_pkg::OP_WRITE: begin
          if (wo_sel != pid_ext) begin
            status_nxt = mcpt_pkg::ST_REFUSED;
          end else if (fill_sel == mcpt_pkg::CNT_W'(mcpt_pkg::RING_DEPTH)) begin
            status_nxt = mcpt_pkg::ST_FULL;
          end else begin
            ram_we        = 1'b1;
            wp_nxt[idx]   = (wp_sel == mcpt_pkg::PTR_W'(mcpt_pkg::RING_DEPTH - 1)) ?
                            '0 : wp_sel + 1'b1;
            fill_nxt[idx] = fill_sel + 1'b1;
          end
        end
        mcpt_pkg::OP_READ: begin
          if (ro_sel != pid_ext) begin
            status_nxt = mcpt_pkg::ST_REFUSED;
          end else if (fill_sel == '0) begin
            status_nxt = (wo_sel == mcpt_pkg::OWNER_NONE) ? mcpt_pkg::ST_EOD :
                                                            mcpt_pkg::ST_EMPTY;
          end else begin
            ram_re          = 1'b1;
            dp_status.rd_ok = 1'b1;
            rp_nxt[idx]     = (rp_sel == mcpt_pkg::PTR_W'(mcpt_pkg::RING_DEPTH - 1)) ?
                              '0 : rp_sel + 1'b1;
            fill_nxt[idx]   = fill_sel - 1'b1;
          end
        end
        mcpt_pkg::OP_QUERY: begin
          owner_nxt = in_role ? wo_sel : ro_sel;
        end
        default: begin
          status_nxt = mcpt_pkg::ST_BAD_ID;
        end
      endcase
    end
  end

  // Commit table state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < P; i++) begin
        ro_r[i]   <= mcpt_pkg::OWNER_NONE;
        wo_r[i]   <= mcpt_pkg::OWNER_NONE;
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
      free_r <= '1;
    end else if (dp_cmd.accept) begin
      ro_r   <= ro_nxt;
      wo_r   <= wo_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      free_r <= free_nxt;
    end
  end

  // Ring storage, addressed by pipe and pointer
  mcpt_ram #(
    .WIDTH (mcpt_pkg::BYTE_W),
    .DEPTH (mcpt_pkg::RAM_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (dp_cmd.accept && ram_we),
    .wr_addr ({idx, wp_sel}),
    .wr_data (in_data_in),
    .rd_en   (dp_cmd.accept && ram_re),
    .rd_addr ({idx, rp_sel}),
    .rd_data (ram_rd_data)
  );

  // Result register: load fields on accept, byte when the ring data lands
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      status_r <= status_nxt;
      owner_r  <= owner_nxt;
      pipe_r   <= pipe_nxt;
      eot_r    <= in_end_of_transfer;
      data_r   <= '0;
    end else if (dp_cmd.rd_fill) begin
      data_r   <= ram_rd_data;
    end
  end

  assign out_status              = status_r;
  assign out_data_out            = data_r;
  assign out_owner_out           = owner_r;
  assign out_pipe_out            = pipe_r;
  assign out_end_of_transfer_out = eot_r;

endmodule

// ----- sv/multi_channel_pipe_table_unit.sv -----
// Top level of the pipe table: byte mailboxes with reader and writer owners.
//
// Usage: one operation per input beat (allocate, open, close, write byte,
// read byte, query owner) on the in_ channel; exactly one result beat per
// operation on the out_ channel, in order. Both channels use valid/stall:
// a beat moves on a rising edge with valid high and stall low.
// Timing: a result is registered after its input beat; a read that returns a
// byte also passes through the CS_READ wait state, because the ring memory read
// port is registered and the byte lands in the cycle after the address.
// Throughput: one beat per cycle while out_stall is low, except that no new beat
// is taken while the controller waits out the ring memory read of a byte.
// Reset (rst_n low, synchronous): every pipe is free with no owners and empty
// pointers; no result is pending. Ring contents are not cleared; a byte is
// only read after it was written.
// Receiver stall: the result register holds its beat; a new input beat is
// still taken when the result register is draining in that same cycle,
// otherwise in_stall rises until the result is taken.
module multi_channel_pipe_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcpt_pkg::OP_W-1:0]           in_op,
  input  logic [mcpt_pkg::ID_W-1:0]           in_pipe_id,
  input  logic                                in_role,
  input  logic [mcpt_pkg::PID_W-1:0]          in_pid,
  input  logic [mcpt_pkg::BYTE_W-1:0]         in_data_in,
  input  logic                                in_end_of_transfer,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcpt_pkg::STATUS_W-1:0]       out_status,
  output logic [mcpt_pkg::BYTE_W-1:0]         out_data_out,
  output logic signed [mcpt_pkg::OWNER_W-1:0] out_owner_out,
  output logic [mcpt_pkg::ID_W-1:0]           out_pipe_out,
  output logic                                out_end_of_transfer_out
);

  mcpt_pkg::dp_cmd_t    dp_cmd;
  mcpt_pkg::dp_status_t dp_status;

  // Sequencing and handshake
  mcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // Table state, ring memory and result register
  mcpt_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_op                   (in_op),
    .in_pipe_id              (in_pipe_id),
    .in_role                 (in_role),
    .in_pid                  (in_pid),
    .in_data_in              (in_data_in),
    .in_end_of_transfer      (in_end_of_transfer),
    .out_status              (out_status),
    .out_data_out            (out_data_out),
    .out_owner_out           (out_owner_out),
    .out_pipe_out            (out_pipe_out),
    .out_end_of_transfer_out (out_end_of_transfer_out),
    .dp_cmd                  (dp_cmd),
    .dp_status               (dp_status)
  );

endmodule

// ----- tb/tb_multi_channel_pipe_table_unit.sv -----
// Self-checking testbench for the pipe table: directed and random mailbox traffic, scoreboard.
module tb_multi_channel_pipe_table_unit;
  import mcpt_pkg::*;

  localparam int TOTAL_OPS   = 1150;
  localparam int PHASE1_OPS  = 400;
  localparam int PHASE2_OPS  = 800;
  localparam int HOLD_CYCLES = 60;
  localparam int WATCHDOG    = 2000;
  localparam int DRAIN       = 4;
  localparam int PID_MAX     = (1 << PID_W) - 1;
  localparam int ID_MAX      = (1 << ID_W) - 1;
  localparam int BYTE_MAX    = (1 << BYTE_W) - 1;
  // Opcodes beyond the defined set
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   pipe_id;
    logic              role;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] data;
    logic              eot;
  } mailbox_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic [OWNER_W-1:0]  owner;
    logic [ID_W-1:0]     pipe;
    logic                eot;
  } mailbox_reply_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [OP_W-1:0]               in_op = '0;
  logic [ID_W-1:0]               in_pipe_id = '0;
  logic                          in_role = 1'b0;
  logic [PID_W-1:0]              in_pid = '0;
  logic [BYTE_W-1:0]             in_data_in = '0;
  logic                          in_end_of_transfer = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [STATUS_W-1:0]           out_status;
  logic [BYTE_W-1:0]             out_data_out;
  logic signed [OWNER_W-1:0]     out_owner_out;
  logic [ID_W-1:0]               out_pipe_out;
  logic                          out_end_of_transfer_out;

  multi_channel_pipe_table_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_op                   (in_op),
    .in_pipe_id              (in_pipe_id),
    .in_role                 (in_role),
    .in_pid                  (in_pid),
    .in_data_in              (in_data_in),
    .in_end_of_transfer      (in_end_of_transfer),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_data_out            (out_data_out),
    .out_owner_out           (out_owner_out),
    .out_pipe_out            (out_pipe_out),
    .out_end_of_transfer_out (out_end_of_transfer_out)
  );

  always #2 clk = ~clk;

  // Two copies of the pipe table: [0] steers the generator, [1] predicts replies
  logic [OWNER_W-1:0] rd_own    [2][PIPES];
  logic [OWNER_W-1:0] wr_own    [2][PIPES];
  logic               pipe_free [2][PIPES];
  int                 rd_ptr    [2][PIPES];
  int                 wr_ptr    [2][PIPES];
  int                 fill      [2][PIPES];
  logic [BYTE_W-1:0]  ring      [2][PIPES][RING_DEPTH];

  mailbox_op_t    mailbox_ops [$];
  mailbox_reply_t expected_replies [$];
  mailbox_op_t    next_op;
  mailbox_reply_t want_reply;
  mailbox_reply_t got_reply;

  logic in_took = 1'b0;
  int   ops_taken = 0;
  int   replies_checked = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  int   holds_done = 0;
  int   status_seen [8];
  int   send_pct;
  int   recv_pct;

  function automatic int ring_bump(int p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one operation to table copy v and return its reply
  function automatic mailbox_reply_t mailbox_step(int v, mailbox_op_t it);
    mailbox_reply_t r;
    int id;
    logic found;
    logic released;
    logic [OWNER_W-1:0] who;
    r.status = ST_OK;
    r.data = '0;
    r.owner = OWNER_NONE;
    r.pipe = '0;
    r.eot = it.eot;
    id = int'(it.pipe_id);
    who = {1'b0, it.pid};
    found = 1'b0;
    released = 1'b0;
    if (it.op == OP_ALLOC) begin
      // First fit over pipes that are free with no owners
      r.status = ST_NO_FREE;
      for (int i = 0; i < PIPES; i++) begin
        if (!found && pipe_free[v][i] && rd_own[v][i] == OWNER_NONE &&
            wr_own[v][i] == OWNER_NONE) begin
          found = 1'b1;
          pipe_free[v][i] = 1'b0;
          r.status = ST_OK;
          r.pipe = ID_W'(i);
        end
      end
    end else if (it.op > OP_QUERY || id >= PIPES) begin
      r.status = ST_BAD_ID;
    end else if (it.op == OP_OPEN) begin
      if (it.role) begin
        if (wr_own[v][id] != OWNER_NONE) r.status = ST_REFUSED;
        else wr_own[v][id] = who;
      end else begin
        if (rd_own[v][id] != OWNER_NONE) r.status = ST_REFUSED;
        else rd_own[v][id] = who;
      end
    end else if (it.op == OP_CLOSE) begin
      // Release every role held by the caller; free the pipe once ownerless
      if (rd_own[v][id] == who) begin
        rd_own[v][id] = OWNER_NONE;
        released = 1'b1;
      end
      if (wr_own[v][id] == who) begin
        wr_own[v][id] = OWNER_NONE;
        released = 1'b1;
      end
      if (rd_own[v][id] == OWNER_NONE && wr_own[v][id] == OWNER_NONE) begin
        rd_ptr[v][id] = 0;
        wr_ptr[v][id] = 0;
        fill[v][id] = 0;
        pipe_free[v][id] = 1'b1;
      end
      r.status = released ? ST_OK : ST_REFUSED;
    end else if (it.op == OP_WRITE) begin
      if (wr_own[v][id] != who) begin
        r.status = ST_REFUSED;
      end else if (fill[v][id] >= RING_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        ring[v][id][wr_ptr[v][id]] = it.data;
        wr_ptr[v][id] = ring_bump(wr_ptr[v][id]);
        fill[v][id]++;
      end
    end else if (it.op == OP_READ) begin
      if (rd_own[v][id] != who) begin
        r.status = ST_REFUSED;
      end else if (fill[v][id] == 0) begin
        r.status = (wr_own[v][id] == OWNER_NONE) ? ST_EOD : ST_EMPTY;
      end else begin
        r.data = ring[v][id][rd_ptr[v][id]];
        rd_ptr[v][id] = ring_bump(rd_ptr[v][id]);
        fill[v][id]--;
      end
    end else begin
      r.owner = it.role ? wr_own[v][id] : rd_own[v][id];
    end
    return r;
  endfunction

  function automatic mailbox_op_t mailbox_op(logic [OP_W-1:0] op, int id, int role, int pid,
                                             int data, int eot);
    mailbox_op_t it;
    it.op = op;
    it.pipe_id = ID_W'(id);
    it.role = role[0];
    it.pid = PID_W'(pid);
    it.data = BYTE_W'(data);
    it.eot = eot[0];
    return it;
  endfunction

  // Queue an operation for the driver and advance the generator's table
  function automatic mailbox_reply_t issue(mailbox_op_t it);
    mailbox_ops.push_back(it);
    return mailbox_step(0, it);
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Idle mix per phase: sender-light, receiver-light, then none
  always_comb begin
    send_pct = (ops_taken < PHASE1_OPS) ? 27 : (ops_taken < PHASE2_OPS) ? 82 : 0;
    recv_pct = (ops_taken < PHASE1_OPS) ? 82 : (ops_taken < PHASE2_OPS) ? 27 : 0;
  end

  // Driver: hold a stalled beat, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (mailbox_ops.size() != 0 && $urandom_range(99) >= send_pct) begin
        next_op = mailbox_ops.pop_front();
        in_op <= next_op.op;
        in_pipe_id <= next_op.pipe_id;
        in_role <= next_op.role;
        in_pid <= next_op.pid;
        in_data_in <= next_op.data;
        in_end_of_transfer <= next_op.eot;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs that back the block up
  always @(negedge clk) begin
    if (hold_left == 0 && holds_done < 2 &&
        ops_taken >= ((holds_done == 0) ? 380 : 1000)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_replies.push_back(mailbox_step(1, {in_op, in_pipe_id, in_role, in_pid,
                                                  in_data_in, in_end_of_transfer}));
      ops_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got_reply = {out_status, out_data_out, out_owner_out, out_pipe_out,
                   out_end_of_transfer_out};
      if (expected_replies.size() == 0) begin
        $error("unexpected result beat, status %0d", out_status);
        mismatches++;
      end else begin
        want_reply = expected_replies.pop_front();
        check_field("status", 16'(want_reply.status), 16'(got_reply.status));
        check_field("data_out", 16'(want_reply.data), 16'(got_reply.data));
        check_field("owner_out", want_reply.owner, got_reply.owner);
        check_field("pipe_out", 16'(want_reply.pipe), 16'(got_reply.pipe));
        check_field("end_of_transfer_out", 16'(want_reply.eot), 16'(got_reply.eot));
        status_seen[want_reply.status]++;
        replies_checked++;
      end
    end
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog: give up when neither channel moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG);
    $error("no beat for %0d cycles", WATCHDOG);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    mailbox_reply_t r;
    int p;
    int k;
    int wbias;
    int c;
    int pa;
    int pb;
    bit burst_done;
    burst_done = 1'b0;
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < PIPES; i++) begin
        rd_own[v][i] = OWNER_NONE;
        wr_own[v][i] = OWNER_NONE;
        pipe_free[v][i] = 1'b1;
        rd_ptr[v][i] = 0;
        wr_ptr[v][i] = 0;
        fill[v][i] = 0;
      end
    end

    // Directed: reset query, allocate all, reuse, ownership and data path corners
    void'(issue(mailbox_op(OP_QUERY, 0, 0, 0, 0, 0)));
    repeat (PIPES) void'(issue(mailbox_op(OP_ALLOC, ID_MAX, 1, PID_MAX, BYTE_MAX, 1)));
    void'(issue(mailbox_op(OP_ALLOC, 0, 0, 0, 0, 0)));
    void'(issue(mailbox_op(OP_CLOSE, 5, 0, 1, 0, 0)));
    void'(issue(mailbox_op(OP_ALLOC, 0, 0, 0, 0, 1)));
    void'(issue(mailbox_op(OP_OPEN, 0, 0, PID_MAX, 0, 0)));
    void'(issue(mailbox_op(OP_OPEN, 0, 1, 0, 0, 0)));
    void'(issue(mailbox_op(OP_OPEN, 0, 0, 3, 0, 0)));
    void'(issue(mailbox_op(OP_WRITE, 0, 1, 3, BYTE_MAX, 0)));
    void'(issue(mailbox_op(OP_WRITE, 0, 1, 0, BYTE_MAX, 1)));
    void'(issue(mailbox_op(OP_WRITE, 0, 1, 0, 0, 0)));
    void'(issue(mailbox_op(OP_READ, 0, 0, 0, 0, 0)));
    void'(issue(mailbox_op(OP_READ, 0, 0, PID_MAX, 0, 1)));
    void'(issue(mailbox_op(OP_READ, 0, 0, PID_MAX, 0, 0)));
    void'(issue(mailbox_op(OP_READ, 0, 0, PID_MAX, 0, 0)));
    void'(issue(mailbox_op(OP_CLOSE, 0, 1, 0, 0, 0)));
    void'(issue(mailbox_op(OP_READ, 0, 0, PID_MAX, 0, 0)));
    void'(issue(mailbox_op(OP_QUERY, 0, 1, 0, 0, 0)));
    void'(issue(mailbox_op(OP_QUERY, 0, 0, 0, 0, 1)));
    void'(issue(mailbox_op(OP_UNDEF_LO, 0, 0, 0, 0, 0)));
    void'(issue(mailbox_op(OP_UNDEF_HI, ID_MAX, 1, PID_MAX, BYTE_MAX, 1)));
    void'(issue(mailbox_op(OP_WRITE, ID_MAX, 1, 0, 0, 0)));
    void'(issue(mailbox_op(OP_QUERY, PIPES, 0, 0, 0, 0)));
    // One pid owning both ends gives both up in a single close
    void'(issue(mailbox_op(OP_OPEN, 2, 0, 'h1234, 0, 0)));
    void'(issue(mailbox_op(OP_OPEN, 2, 1, 'h1234, 0, 0)));
    void'(issue(mailbox_op(OP_CLOSE, 2, 0, 'h1234, 0, 1)));

    // Random: mostly well-formed sessions, some noise, one fill-to-full-and-drain run
    while (mailbox_ops.size() < TOTAL_OPS) begin
      c = $urandom_range(99);
      if (!burst_done && mailbox_ops.size() > 300) begin
        burst_done = 1'b1;
        p = $urandom_range(PIPES - 1);
        if (rd_own[0][p] != OWNER_NONE)
          void'(issue(mailbox_op(OP_CLOSE, p, 0, int'(rd_own[0][p]), 0, 0)));
        if (wr_own[0][p] != OWNER_NONE)
          void'(issue(mailbox_op(OP_CLOSE, p, 0, int'(wr_own[0][p]), 0, 0)));
        pa = $urandom_range(PID_MAX);
        pb = $urandom_range(PID_MAX);
        void'(issue(mailbox_op(OP_OPEN, p, 0, pa, 0, 0)));
        void'(issue(mailbox_op(OP_OPEN, p, 1, pb, 0, 0)));
        repeat (RING_DEPTH + 1)
          void'(issue(mailbox_op(OP_WRITE, p, 1, pb, $urandom_range(BYTE_MAX),
                                 $urandom_range(1))));
        repeat (RING_DEPTH + 1)
          void'(issue(mailbox_op(OP_READ, p, 0, pa, 0, $urandom_range(1))));
        void'(issue(mailbox_op(OP_CLOSE, p, 1, pb, 0, 0)));
        void'(issue(mailbox_op(OP_CLOSE, p, 0, pa, 0, 0)));
      end else if (c < 25) begin
        p = ($urandom_range(1) != 0) ? $urandom_range(ID_MAX) : $urandom_range(PIPES - 1);
        void'(issue(mailbox_op(OP_W'($urandom_range(7)), p, $urandom_range(1),
                               $urandom_range(PID_MAX), $urandom_range(BYTE_MAX),
                               $urandom_range(1))));
      end else begin
        if ($urandom_range(3) == 0) begin
          r = issue(mailbox_op(OP_ALLOC, $urandom_range(ID_MAX), $urandom_range(1),
                               $urandom_range(PID_MAX), $urandom_range(BYTE_MAX),
                               $urandom_range(1)));
          p = (r.status == ST_OK) ? int'(r.pipe) : $urandom_range(PIPES - 1);
        end else begin
          p = $urandom_range(PIPES - 1);
        end
        pa = $urandom_range(PID_MAX);
        pb = ($urandom_range(7) == 0) ? pa : $urandom_range(PID_MAX);
        if (rd_own[0][p] == OWNER_NONE)
          void'(issue(mailbox_op(OP_OPEN, p, 0, pa, 0, $urandom_range(1))));
        // Leave the writer end unowned now and then so reads run dry
        if (wr_own[0][p] == OWNER_NONE && $urandom_range(3) != 0)
          void'(issue(mailbox_op(OP_OPEN, p, 1, pb, 0, $urandom_range(1))));
        pa = int'(rd_own[0][p][PID_W-1:0]);
        pb = int'(wr_own[0][p][PID_W-1:0]);
        k = $urandom_range(24, 1);
        wbias = $urandom_range(80, 20);
        repeat (k) begin
          c = $urandom_range(99);
          if (c < 5)
            void'(issue(mailbox_op(c[0] ? OP_WRITE : OP_READ, p, $urandom_range(1),
                                   $urandom_range(PID_MAX), $urandom_range(BYTE_MAX),
                                   $urandom_range(1))));
          else if (c < wbias)
            void'(issue(mailbox_op(OP_WRITE, p, 1, pb, $urandom_range(BYTE_MAX),
                                   $urandom_range(1))));
          else
            void'(issue(mailbox_op(OP_READ, p, 0, pa, 0, $urandom_range(1))));
        end
        c = $urandom_range(9);
        if (c < 3) void'(issue(mailbox_op(OP_CLOSE, p, 1, pb, 0, $urandom_range(1))));
        else if (c < 5) void'(issue(mailbox_op(OP_CLOSE, p, 0, pa, 0, $urandom_range(1))));
        else if (c == 5)
          void'(issue(mailbox_op(OP_QUERY, p, $urandom_range(1), 0, 0, $urandom_range(1))));
      end
    end

    // Release reset at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all beats sent, all replies back, then a few quiet cycles
    while (mailbox_ops.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Checked %0d replies: %0d ok, %0d refused, %0d full, %0d empty, %0d end of data,",
             replies_checked, status_seen[ST_OK], status_seen[ST_REFUSED],
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_EOD]);
    $display("%0d none free, %0d bad id; ring filled and drained, %0d receiver hold-offs.",
             status_seen[ST_NO_FREE], status_seen[ST_BAD_ID], holds_done);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
